FILE: rtl/thdepq_pkg.sv
// ----------------------------------------------------------------------------
// thdepq_pkg
// Shared constants and types for the twin heap double-ended priority queue.
// ----------------------------------------------------------------------------
package thdepq_pkg;

    localparam int DEFAULT_DEPTH     = 64;
    localparam int DEFAULT_KEY_WIDTH = 32;
    localparam int CAP_WIDTH         = 7;
    localparam int OP_WIDTH          = 2;
    localparam int STATUS_WIDTH      = 2;

    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 7'd64;

    localparam logic [OP_WIDTH-1:0] OPC_INSERT     = 2'd0;
    localparam logic [OP_WIDTH-1:0] OPC_REMOVE_MIN = 2'd1;
    localparam logic [OP_WIDTH-1:0] OPC_REMOVE_MAX = 2'd2;

    localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd2;

    localparam logic HEAP_MIN = 1'b0;
    localparam logic HEAP_MAX = 1'b1;

    // One datapath action per controller state.
    typedef enum logic [3:0] {
        DP_IDLE,
        DP_ACCEPT,
        DP_UP_RD,
        DP_UP_CHK,
        DP_DN_RD,
        DP_DN_LEFT,
        DP_DN_RIGHT,
        DP_DN_CHK,
        DP_INS_MIN,
        DP_RM_ROOT,
        DP_RM_LAST,
        DP_RM_TWIN,
        DP_RM_TLOAD,
        DP_FINISH
    } dp_op_t;

    typedef struct packed {
        logic ins_ok;
        logic ins_full;
        logic rm_ok;
        logic rm_empty;
        logic has_parent;
        logic up_better;
        logic has_left;
        logic has_right;
        logic child_better;
        logic rm_more;
        logic twin_live;
    } dp_flags_t;

endpackage

FILE: rtl/twin_heap_double_ended_priority_queue_core.sv
// Sequence: a refused or ignored transaction goes from acceptance to the finish state,
// which raises done. Rising a heap level reads the parent, then compares and moves it;
// sinking reads the left child, then the right child if there is one, then compares and writes.
// Throughput: one transaction at a time; busy drops as done rises, so the next
// transaction may be accepted in the done cycle. Results cannot be stalled.
// Reset empties the queue and sets the capacity limit to 64; heap memories are not cleared.
// ----------------------------------------------------------------------------
// twin_heap_double_ended_priority_queue_core
// Double-ended priority queue held as a linked min heap and max heap.
// ----------------------------------------------------------------------------
module twin_heap_double_ended_priority_queue_core #(
    parameter int DEPTH     = thdepq_pkg::DEFAULT_DEPTH,
    parameter int KEY_WIDTH = thdepq_pkg::DEFAULT_KEY_WIDTH,
    localparam int PW       = $clog2(DEPTH + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [thdepq_pkg::OP_WIDTH-1:0]     operation,
    input  logic signed [KEY_WIDTH-1:0]         key_in,
    input  logic                                cfg_wr_en,
    input  logic [thdepq_pkg::CAP_WIDTH-1:0]    cfg_wr_data,
    output logic                                done,
    output logic signed [KEY_WIDTH-1:0]         key_out,
    output logic [thdepq_pkg::STATUS_WIDTH-1:0] status,
    output logic [PW-1:0]                       occupancy
);
    import thdepq_pkg::*;

    dp_op_t    op;
    dp_flags_t flags;

    thdepq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .busy  (busy),
        .op    (op)
    );

    thdepq_datapath #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .flags       (flags),
        .operation   (operation),
        .key_in      (key_in),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .key_out     (key_out),
        .status      (status),
        .occupancy   (occupancy)
    );

endmodule

FILE: rtl/thdepq_datapath.sv
// ----------------------------------------------------------------------------
// thdepq_datapath
// Heap memories, sift registers, comparators and result registers.
// ----------------------------------------------------------------------------
module thdepq_datapath #(
    parameter int DEPTH     = thdepq_pkg::DEFAULT_DEPTH,
    parameter int KEY_WIDTH = thdepq_pkg::DEFAULT_KEY_WIDTH,
    localparam int PW       = $clog2(DEPTH + 1)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  thdepq_pkg::dp_op_t                    op,
    output thdepq_pkg::dp_flags_t                 flags,
    input  logic [thdepq_pkg::OP_WIDTH-1:0]       operation,
    input  logic signed [KEY_WIDTH-1:0]           key_in,
    input  logic                                  cfg_wr_en,
    input  logic [thdepq_pkg::CAP_WIDTH-1:0]      cfg_wr_data,
    output logic                                  done,
    output logic signed [KEY_WIDTH-1:0]           key_out,
    output logic [thdepq_pkg::STATUS_WIDTH-1:0]   status,
    output logic [PW-1:0]                         occupancy
);
    import thdepq_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CMPW = (PW > CAP_WIDTH) ? PW : CAP_WIDTH;

    logic signed [KEY_WIDTH-1:0] min_key_mem  [DEPTH];
    logic signed [KEY_WIDTH-1:0] max_key_mem  [DEPTH];
    logic [PW-1:0]               min_twin_mem [DEPTH];
    logic [PW-1:0]               max_twin_mem [DEPTH];

    logic [CAP_WIDTH-1:0]        cap_reg;
    logic [PW-1:0]               count_reg, count_next;
    logic                        done_reg, done_next;
    logic [PW-1:0]               lim_reg, lim_next;
    logic [PW-1:0]               pos_reg, pos_next;
    logic [PW-1:0]               child_pos_reg, child_pos_next;
    logic [PW-1:0]               twin_pos_reg, twin_pos_next;
    logic                        sel_reg, sel_next;
    logic signed [KEY_WIDTH-1:0] cur_key_reg, cur_key_next;
    logic [PW-1:0]               cur_twin_reg, cur_twin_next;
    logic signed [KEY_WIDTH-1:0] child_key_reg, child_key_next;
    logic [PW-1:0]               child_twin_reg, child_twin_next;
    logic signed [KEY_WIDTH-1:0] res_key_reg, res_key_next;
    logic [STATUS_WIDTH-1:0]     status_reg, status_next;
    logic signed [KEY_WIDTH-1:0] rd_key_reg;
    logic [PW-1:0]               rd_twin_reg;

    logic                        rd_en, rd_heap;
    logic [PW-1:0]               rd_pos;
    logic                        wr_en;
    logic [PW-1:0]               wr_pos;
    logic signed [KEY_WIDTH-1:0] wr_key;
    logic [PW-1:0]               wr_twin;

    logic [PW-1:0]               parent_pos, count_plus;
    logic [PW:0]                 left_pos, right_pos;
    logic                        is_ins, is_rm, full, empty, right_better;

    function automatic logic [AW-1:0] slot_index(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        q = p - PW'(1);
        return q[AW-1:0];
    endfunction

    function automatic logic better(input logic is_max,
                                    input logic signed [KEY_WIDTH-1:0] a,
                                    input logic signed [KEY_WIDTH-1:0] b);
        return is_max ? (a > b) : (a < b);
    endfunction

    assign parent_pos = pos_reg >> 1;
    assign left_pos   = {pos_reg, 1'b0};
    assign right_pos  = {pos_reg, 1'b1};
    assign count_plus = count_reg + PW'(1);

    // The limit saturates at the memory depth.
    assign full  = (CMPW'(count_reg) >= CMPW'(cap_reg)) || (count_reg == PW'(DEPTH));
    assign empty = (count_reg == '0);
    assign is_ins = (operation == OPC_INSERT);
    assign is_rm  = (operation == OPC_REMOVE_MIN) || (operation == OPC_REMOVE_MAX);
    assign right_better = better(sel_reg, rd_key_reg, child_key_reg);

    assign flags.ins_ok       = is_ins && !full;
    assign flags.ins_full     = is_ins && full;
    assign flags.rm_ok        = is_rm && !empty;
    assign flags.rm_empty     = is_rm && empty;
    assign flags.has_parent   = (pos_reg > PW'(1));
    assign flags.up_better    = better(sel_reg, cur_key_reg, rd_key_reg);
    assign flags.has_left     = (left_pos <= {1'b0, lim_reg});
    assign flags.has_right    = (right_pos <= {1'b0, lim_reg});
    assign flags.child_better = better(sel_reg, child_key_reg, cur_key_reg);
    assign flags.rm_more      = (count_reg > PW'(1));
    assign flags.twin_live    = (twin_pos_reg <= count_reg);

    always_comb
    begin
        count_next      = count_reg;
        done_next       = 1'b0;
        lim_next        = lim_reg;
        pos_next        = pos_reg;
        child_pos_next  = child_pos_reg;
        twin_pos_next   = twin_pos_reg;
        sel_next        = sel_reg;
        cur_key_next    = cur_key_reg;
        cur_twin_next   = cur_twin_reg;
        child_key_next  = child_key_reg;
        child_twin_next = child_twin_reg;
        res_key_next    = res_key_reg;
        status_next     = status_reg;
        rd_en           = 1'b0;
        rd_heap         = sel_reg;
        rd_pos          = pos_reg;
        wr_en           = 1'b0;
        wr_pos          = pos_reg;
        wr_key          = cur_key_reg;
        wr_twin         = cur_twin_reg;
        unique case (op)
            DP_IDLE:
            begin
            end
            DP_ACCEPT:
            begin
                res_key_next = '0;
                status_next  = ST_OK;
                if (flags.ins_full)
                    status_next = ST_FULL;
                if (flags.rm_empty)
                    status_next = ST_EMPTY;
                if (flags.ins_ok)
                begin
                    cur_key_next  = key_in;
                    cur_twin_next = count_plus;
                    pos_next      = count_plus;
                    lim_next      = count_plus;
                    count_next    = count_plus;
                    sel_next      = HEAP_MAX;
                end
                if (flags.rm_ok)
                begin
                    sel_next = (operation == OPC_REMOVE_MAX) ? HEAP_MAX : HEAP_MIN;
                    rd_en    = 1'b1;
                    rd_heap  = (operation == OPC_REMOVE_MAX) ? HEAP_MAX : HEAP_MIN;
                    rd_pos   = PW'(1);
                end
            end
            DP_UP_RD:
            begin
                if (flags.has_parent)
                begin
                    rd_en  = 1'b1;
                    rd_pos = parent_pos;
                end
            end
            DP_UP_CHK:
            begin
                // The parent drops into the hole; the moving entry stays in registers.
                if (flags.up_better)
                begin
                    wr_en    = 1'b1;
                    wr_key   = rd_key_reg;
                    wr_twin  = rd_twin_reg;
                    pos_next = parent_pos;
                end
            end
            DP_DN_RD:
            begin
                if (flags.has_left)
                begin
                    rd_en  = 1'b1;
                    rd_pos = left_pos[PW-1:0];
                end
                else
                    wr_en = 1'b1;
            end
            DP_DN_LEFT:
            begin
                child_key_next  = rd_key_reg;
                child_twin_next = rd_twin_reg;
                child_pos_next  = left_pos[PW-1:0];
                if (flags.has_right)
                begin
                    rd_en  = 1'b1;
                    rd_pos = right_pos[PW-1:0];
                end
            end
            DP_DN_RIGHT:
            begin
                if (right_better)
                begin
                    child_key_next  = rd_key_reg;
                    child_twin_next = rd_twin_reg;
                    child_pos_next  = right_pos[PW-1:0];
                end
            end
            DP_DN_CHK:
            begin
                wr_en = 1'b1;
                if (flags.child_better)
                begin
                    wr_key   = child_key_reg;
                    wr_twin  = child_twin_reg;
                    pos_next = child_pos_reg;
                end
            end
            DP_INS_MIN:
            begin
                cur_twin_next = pos_reg;
                pos_next      = count_reg;
                sel_next      = HEAP_MIN;
            end
            DP_RM_ROOT:
            begin
                res_key_next  = rd_key_reg;
                twin_pos_next = rd_twin_reg;
                rd_en         = 1'b1;
                rd_pos        = count_reg;
            end
            DP_RM_LAST:
            begin
                cur_key_next  = rd_key_reg;
                cur_twin_next = rd_twin_reg;
                count_next    = count_reg - PW'(1);
                lim_next      = count_reg - PW'(1);
                pos_next      = PW'(1);
            end
            DP_RM_TWIN:
            begin
                // The last slot of the other heap fills the twin's hole.
                if (flags.twin_live)
                begin
                    rd_en   = 1'b1;
                    rd_heap = ~sel_reg;
                    rd_pos  = count_plus;
                end
            end
            DP_RM_TLOAD:
            begin
                cur_key_next  = rd_key_reg;
                cur_twin_next = rd_twin_reg;
                pos_next      = twin_pos_reg;
                sel_next      = ~sel_reg;
                lim_next      = count_reg;
            end
            DP_FINISH:
                done_next = 1'b1;
            default:
            begin
            end
        endcase
    end

    // Each placement also points the twin in the other heap back at its new slot.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (sel_reg == HEAP_MAX)
            begin
                max_key_mem[slot_index(wr_pos)]   <= wr_key;
                max_twin_mem[slot_index(wr_pos)]  <= wr_twin;
                min_twin_mem[slot_index(wr_twin)] <= wr_pos;
            end
            else
            begin
                min_key_mem[slot_index(wr_pos)]   <= wr_key;
                min_twin_mem[slot_index(wr_pos)]  <= wr_twin;
                max_twin_mem[slot_index(wr_twin)] <= wr_pos;
            end
        end
        if (rd_en)
        begin
            if (rd_heap == HEAP_MAX)
            begin
                rd_key_reg  <= max_key_mem[slot_index(rd_pos)];
                rd_twin_reg <= max_twin_mem[slot_index(rd_pos)];
            end
            else
            begin
                rd_key_reg  <= min_key_mem[slot_index(rd_pos)];
                rd_twin_reg <= min_twin_mem[slot_index(rd_pos)];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg        <= lim_next;
        pos_reg        <= pos_next;
        child_pos_reg  <= child_pos_next;
        twin_pos_reg   <= twin_pos_next;
        sel_reg        <= sel_next;
        cur_key_reg    <= cur_key_next;
        cur_twin_reg   <= cur_twin_next;
        child_key_reg  <= child_key_next;
        child_twin_reg <= child_twin_next;
        res_key_reg    <= res_key_next;
        status_reg     <= status_next;
    end

    assign done      = done_reg;
    assign key_out   = res_key_reg;
    assign status    = status_reg;
    assign occupancy = count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= PW'(DEPTH))
        else $error("occupancy beyond depth");
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (op == DP_ACCEPT && flags.ins_full)
        |=> (count_reg == $past(count_reg) && status_reg == ST_FULL))
        else $error("refused insert changed occupancy");
    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        (op == DP_ACCEPT && flags.ins_ok) |=> count_reg == PW'($past(count_reg) + PW'(1)))
        else $error("insert did not grow occupancy by one");
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_pos != '0 && wr_pos <= lim_reg && wr_twin != '0))
        else $error("heap write outside live slots");
    a_err_key: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != ST_OK) |-> res_key_reg == '0)
        else $error("refused transaction returned a key");
`endif

endmodule

FILE: rtl/thdepq_ctrl.sv
// ----------------------------------------------------------------------------
// thdepq_ctrl
// Sequencer for insert, removal and the shared sift loop.
// ----------------------------------------------------------------------------
module thdepq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  thdepq_pkg::dp_flags_t flags,
    output logic                  busy,
    output thdepq_pkg::dp_op_t    op
);
    import thdepq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CHK,
        S_DN_RD,
        S_DN_LEFT,
        S_DN_RIGHT,
        S_DN_CHK,
        S_INS_MIN,
        S_RM_ROOT,
        S_RM_LAST,
        S_RM_TWIN,
        S_RM_TLOAD,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        op         = DP_IDLE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op = DP_ACCEPT;
                    if (flags.ins_ok)
                    begin
                        state_next = S_UP_RD;
                        ret_next   = S_INS_MIN;
                    end
                    else if (flags.rm_ok)
                        state_next = S_RM_ROOT;
                    else
                        state_next = S_FINISH;
                end
            end
            S_UP_RD:
            begin
                op = DP_UP_RD;
                state_next = flags.has_parent ? S_UP_CHK : S_DN_RD;
            end
            S_UP_CHK:
            begin
                // An entry that cannot rise any further is tried downwards.
                op = DP_UP_CHK;
                state_next = flags.up_better ? S_UP_RD : S_DN_RD;
            end
            S_DN_RD:
            begin
                op = DP_DN_RD;
                state_next = flags.has_left ? S_DN_LEFT : ret_reg;
            end
            S_DN_LEFT:
            begin
                op = DP_DN_LEFT;
                state_next = flags.has_right ? S_DN_RIGHT : S_DN_CHK;
            end
            S_DN_RIGHT:
            begin
                op = DP_DN_RIGHT;
                state_next = S_DN_CHK;
            end
            S_DN_CHK:
            begin
                op = DP_DN_CHK;
                state_next = flags.child_better ? S_DN_RD : ret_reg;
            end
            S_INS_MIN:
            begin
                op = DP_INS_MIN;
                state_next = S_UP_RD;
                ret_next   = S_FINISH;
            end
            S_RM_ROOT:
            begin
                op = DP_RM_ROOT;
                state_next = S_RM_LAST;
            end
            S_RM_LAST:
            begin
                op = DP_RM_LAST;
                if (flags.rm_more)
                begin
                    state_next = S_DN_RD;
                    ret_next   = S_RM_TWIN;
                end
                else
                    state_next = S_RM_TWIN;
            end
            S_RM_TWIN:
            begin
                op = DP_RM_TWIN;
                state_next = flags.twin_live ? S_RM_TLOAD : S_FINISH;
            end
            S_RM_TLOAD:
            begin
                op = DP_RM_TLOAD;
                state_next = S_UP_RD;
                ret_next   = S_FINISH;
            end
            S_FINISH:
            begin
                op = DP_FINISH;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_FINISH;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule
